@@ rtl/core/rtda_pkg.sv @@
// Shared types and constants for the ring transmit descriptor allocator.
// Used by rtda_front, rtda_back and the ring_tx_descriptor_allocator top level.
package rtda_pkg;

	// Default number of descriptors the ring can hold
	localparam int DESC_MAX_DEF = 64;

	// Fixed field widths
	localparam int CFG_W     = 7;
	localparam int LEN_W     = 32;
	localparam int RIDX_W    = 16;
	localparam int OUT_ID_W  = 6;
	localparam int FREE_W    = 7;

	// Descriptor count after reset, before any clamp
	localparam int CFG_RESET = 64;

	// Free-map search: descriptors are scanned in groups of this size
	localparam int GRP_W     = 8;
	localparam int LOW_W     = $clog2(GRP_W);

	typedef enum logic {
		OP_SEND = 1'b0,
		OP_DONE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_SENT    = 2'd0,
		ST_FULL    = 2'd1,
		ST_FREED   = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_EXEC
	} bk_state_t;

	// Classified work item: data is msg_len for a send, done_id for a completion
	typedef struct packed {
		op_t              op;
		logic             in_range;
		logic [LEN_W-1:0] data;
	} work_t;

	// One result transaction
	typedef struct packed {
		status_t             status;
		logic [OUT_ID_W-1:0] desc_id;
		logic [OUT_ID_W-1:0] ring_slot;
		logic [RIDX_W-1:0]   ring_index;
		logic [LEN_W-1:0]    desc_len;
		logic [FREE_W-1:0]   free_left;
	} res_t;

endpackage

@@ rtl/core/rtda_front.sv @@
// Front end of the descriptor allocator: accepts requests, range-checks
// completion ids and holds classified work in a two-entry queue. Uses rtda_pkg.
module rtda_front #(
	parameter int DESC_MAX = rtda_pkg::DESC_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          op,
	input  logic [rtda_pkg::LEN_W-1:0]    msg_len,
	input  logic [rtda_pkg::LEN_W-1:0]    done_id,
	input  logic [$clog2(DESC_MAX+1)-1:0] eff_count,
	output logic                          q_valid,
	input  logic                          q_take,
	output rtda_pkg::work_t               q_item
);
	import rtda_pkg::*;

	work_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	work_t      item_c;
	logic       wr_en;
	logic       rd_en;

	// Classify the incoming transaction
	always_comb begin
		item_c.op       = op_t'(op);
		item_c.in_range = (done_id < LEN_W'(eff_count));
		item_c.data     = (op_t'(op) == OP_DONE) ? done_id : msg_len;
	end

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = ent_q[rd_ptr_q];
	assign wr_en   = push && !full;
	assign rd_en   = q_take && q_valid;

	// Store queue entries
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_q[wr_ptr_q] <= item_c;
		end
	end

	// Advance queue pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

@@ rtl/core/rtda_back.sv @@
// Back end of the descriptor allocator: free-map search, in-flight map,
// ring indices and the result register. Uses rtda_pkg.
module rtda_back #(
	parameter int DESC_MAX = rtda_pkg::DESC_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_take,
	input  rtda_pkg::work_t               q_item,
	input  logic [$clog2(DESC_MAX+1)-1:0] eff_count,
	input  logic                          restart,
	input  logic [$clog2(DESC_MAX+1)-1:0] restart_count,
	output logic                          res_valid,
	input  logic                          res_pop,
	output rtda_pkg::res_t                res
);
	import rtda_pkg::*;

	localparam int ID_W      = (DESC_MAX > 1) ? $clog2(DESC_MAX) : 1;
	localparam int CNT_W     = $clog2(DESC_MAX + 1);
	localparam int NG        = (DESC_MAX + GRP_W - 1) / GRP_W;
	localparam int PAD       = NG * GRP_W;
	localparam int RST_COUNT = (DESC_MAX < CFG_RESET) ? DESC_MAX : CFG_RESET;

	bk_state_t          state_q, state_d;
	work_t              cur_s1;
	logic [DESC_MAX-1:0] map_q;
	logic [CNT_W-1:0]   free_q;
	logic [RIDX_W-1:0]  avail_q, used_q;
	logic [ID_W-1:0]    aslot_q, uslot_q;
	logic [NG-1:0]      gfree_s2;
	logic [LOW_W-1:0]   glow_s2 [NG];
	logic               hit_s2;
	logic               res_valid_q;
	res_t               res_q;

	logic [PAD-1:0]     pm;
	logic [NG-1:0]      gfree_c;
	logic [LOW_W-1:0]   glow_c [NG];
	logic [ID_W-1:0]    cur_id;
	logic               hit_c;
	logic [ID_W-1:0]    pick_id;
	logic               do_exec;
	logic               set_en, clr_en;
	logic [ID_W-1:0]    upd_id;
	logic [CNT_W-1:0]   free_d;
	logic [RIDX_W-1:0]  avail_d, used_d;
	logic [ID_W-1:0]    aslot_d, uslot_d;
	res_t               res_d;

	// Slot that follows a ring index; wrap at the count or at index rollover
	function automatic logic [ID_W-1:0] next_slot(input logic [ID_W-1:0] slot,
			input logic [RIDX_W-1:0] idx, input logic [CNT_W-1:0] cnt);
		logic wrap;
		wrap = (idx == {RIDX_W{1'b1}}) || ((int'(slot) + 1) == int'(cnt));
		return wrap ? '0 : ID_W'(int'(slot) + 1);
	endfunction

	assign cur_id = cur_s1.data[ID_W-1:0];

	// Pad the map so unused positions never look free
	always_comb begin
		for (int i = 0; i < PAD; i++) begin
			if (i < DESC_MAX) begin
				pm[i] = map_q[i];
			end else begin
				pm[i] = 1'b1;
			end
		end
	end

	// First search level: lowest free descriptor within each group
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			gfree_c[g] = 1'b0;
			glow_c[g]  = '0;
			for (int b = GRP_W - 1; b >= 0; b--) begin
				if (!pm[g*GRP_W + b]) begin
					gfree_c[g] = 1'b1;
					glow_c[g]  = LOW_W'(b);
				end
			end
		end
		hit_c = cur_s1.in_range && pm[cur_id];
	end

	// Second search level: lowest group with a free descriptor
	always_comb begin
		pick_id = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (gfree_s2[g]) begin
				pick_id = ID_W'(g*GRP_W + int'(glow_s2[g]));
			end
		end
	end

	// Sequencer: take, scan, execute
	always_comb begin
		state_d = state_q;
		q_take  = 1'b0;
		do_exec = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					q_take  = 1'b1;
					state_d = BK_SCAN;
				end
			end
			BK_SCAN: begin
				state_d = BK_EXEC;
			end
			BK_EXEC: begin
				if (!res_valid_q || res_pop) begin
					do_exec = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Carry out the item and build its result
	always_comb begin
		set_en  = 1'b0;
		clr_en  = 1'b0;
		upd_id  = pick_id;
		free_d  = free_q;
		avail_d = avail_q;
		used_d  = used_q;
		aslot_d = aslot_q;
		uslot_d = uslot_q;
		res_d   = '0;
		if (cur_s1.op == OP_SEND) begin
			if (free_q != '0) begin
				set_en           = 1'b1;
				free_d           = free_q - CNT_W'(1);
				avail_d          = avail_q + RIDX_W'(1);
				aslot_d          = next_slot(aslot_q, avail_q, eff_count);
				res_d.status     = ST_SENT;
				res_d.desc_id    = OUT_ID_W'(pick_id);
				res_d.ring_slot  = OUT_ID_W'(aslot_q);
				res_d.ring_index = avail_d;
				res_d.desc_len   = cur_s1.data;
			end else begin
				res_d.status     = ST_FULL;
				res_d.ring_index = avail_q;
			end
		end else begin
			upd_id          = cur_id;
			used_d          = used_q + RIDX_W'(1);
			uslot_d         = next_slot(uslot_q, used_q, eff_count);
			res_d.ring_slot = OUT_ID_W'(uslot_q);
			res_d.ring_index = used_d;
			if (hit_s2) begin
				clr_en        = 1'b1;
				free_d        = free_q + CNT_W'(1);
				res_d.status  = ST_FREED;
				res_d.desc_id = OUT_ID_W'(cur_id);
			end else begin
				res_d.status  = ST_IGNORED;
			end
		end
		res_d.free_left = FREE_W'(free_d);
	end

	// Latch the work item and the search results
	always_ff @(posedge clk) begin
		if (q_take) begin
			cur_s1 <= q_item;
		end
		if (state_q == BK_SCAN) begin
			gfree_s2 <= gfree_c;
			glow_s2  <= glow_c;
			hit_s2   <= hit_c;
		end
		if (do_exec) begin
			res_q <= res_d;
		end
	end

	// Update ring state; restart clears the map, indices and slots and reloads free_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			map_q       <= '0;
			free_q      <= CNT_W'(RST_COUNT);
			avail_q     <= '0;
			used_q      <= '0;
			aslot_q     <= '0;
			uslot_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (restart) begin
				map_q   <= '0;
				free_q  <= restart_count;
				avail_q <= '0;
				used_q  <= '0;
				aslot_q <= '0;
				uslot_q <= '0;
			end else if (do_exec) begin
				if (set_en) begin
					map_q[upd_id] <= 1'b1;
				end
				if (clr_en) begin
					map_q[upd_id] <= 1'b0;
				end
				free_q  <= free_d;
				avail_q <= avail_d;
				used_q  <= used_d;
				aslot_q <= aslot_d;
				uslot_q <= uslot_d;
			end
			if (do_exec) begin
				res_valid_q <= 1'b1;
			end else if (res_pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

@@ rtl/core/ring_tx_descriptor_allocator.sv @@
// Ring transmit descriptor allocator: a two-entry queue sits in front of a back end
// that finishes each item (take, free-map scan, execute) before taking the next, and
// shows its result (empty low); execute stalls while a result is unpopped.
// Reset (arst_n low) clears the in-flight map and both ring indices and sets the
// descriptor count to 64, clamped to DESC_MAX. A count write restarts the ring.
module ring_tx_descriptor_allocator #(
	parameter int DESC_MAX = rtda_pkg::DESC_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          op,
	input  logic [rtda_pkg::LEN_W-1:0]    msg_len,
	input  logic [rtda_pkg::LEN_W-1:0]    done_id,
	output logic                          empty,
	input  logic                          pop,
	output logic [1:0]                    status,
	output logic [rtda_pkg::OUT_ID_W-1:0] desc_id,
	output logic [rtda_pkg::OUT_ID_W-1:0] ring_slot,
	output logic [rtda_pkg::RIDX_W-1:0]   ring_index,
	output logic [rtda_pkg::LEN_W-1:0]    desc_len,
	output logic [rtda_pkg::FREE_W-1:0]   free_left,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rtda_pkg::CFG_W-1:0]    cfg_data
);
	import rtda_pkg::*;

	localparam int CNT_W     = $clog2(DESC_MAX + 1);
	localparam int RST_COUNT = (DESC_MAX < CFG_RESET) ? DESC_MAX : CFG_RESET;

	logic [CNT_W-1:0] eff_count_q;
	logic [CNT_W-1:0] eff_d;
	logic             restart;
	logic             q_valid, q_take;
	work_t            q_item;
	logic             res_valid;
	res_t             res;

	// Clamp the written count into 1..DESC_MAX
	always_comb begin
		priority if (cfg_data == '0) begin
			eff_d = CNT_W'(1);
		end else if (int'(cfg_data) > DESC_MAX) begin
			eff_d = CNT_W'(DESC_MAX);
		end else begin
			eff_d = CNT_W'(cfg_data);
		end
	end

	assign cfg_ready = 1'b1;
	assign restart   = cfg_valid && cfg_ready;

	// Hold the effective descriptor count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_count_q <= CNT_W'(RST_COUNT);
		end else if (restart) begin
			eff_count_q <= eff_d;
		end
	end

	rtda_front #(
		.DESC_MAX(DESC_MAX)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.op       (op),
		.msg_len  (msg_len),
		.done_id  (done_id),
		.eff_count(eff_count_q),
		.q_valid  (q_valid),
		.q_take   (q_take),
		.q_item   (q_item)
	);

	rtda_back #(
		.DESC_MAX(DESC_MAX)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_take       (q_take),
		.q_item       (q_item),
		.eff_count    (eff_count_q),
		.restart      (restart),
		.restart_count(eff_d),
		.res_valid    (res_valid),
		.res_pop      (pop),
		.res          (res)
	);

	// Drive the result ports
	assign empty      = !res_valid;
	assign status     = res.status;
	assign desc_id    = res.desc_id;
	assign ring_slot  = res.ring_slot;
	assign ring_index = res.ring_index;
	assign desc_len   = res.desc_len;
	assign free_left  = res.free_left;

`ifndef SYNTHESIS
	a_full_means_none_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_FULL) |-> (free_left == '0))
		else $error("ring reported full while descriptors remain free");

	a_free_within_count: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (int'(free_left) <= int'(eff_count_q)))
		else $error("free descriptor count exceeds ring size");

	a_no_desc_on_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (status == ST_FULL || status == ST_IGNORED))
		|-> (desc_id == '0 && desc_len == '0))
		else $error("descriptor fields set on a rejected transaction");
`endif

endmodule
